// File: src/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants for the homogeneous point transform unit.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int COORD_W       = 32;  // Q.F coordinate word
  localparam int CFG_W         = 64;  // one matrix register, two elements
  localparam int MAT_REGS      = 8;   // four rows, two registers per row
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Matrix register contents after reset (identity at 16 fraction bits)
  localparam cfg_word_t MAT_RESET [MAT_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

endpackage

// File: src/hpt_point_if.sv
// ----------------------------------------------------------------------------
// hpt_point_if
// Input point request channel: valid/ready with three coordinates.
// ----------------------------------------------------------------------------
interface hpt_point_if;
  import hpt_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// File: src/hpt_result_if.sv
// ----------------------------------------------------------------------------
// hpt_result_if
// Result request channel: valid/ready with projected point and zero-w flag.
// ----------------------------------------------------------------------------
interface hpt_result_if;
  import hpt_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   w_zero;

  modport source (output valid, output out_x, output out_y, output out_z, output w_zero,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input w_zero,
                  output ready);
endinterface

// File: src/homogeneous_point_transform_unit.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform_unit
// Row vector (x, y, z, 1) times a 4x4 Q.F matrix, then x, y, z divided by w
// with truncation toward zero and saturation to 32 bits.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_if    | in  | valid/ready   | point_x, point_y, point_z
//  out_if   | out | valid/ready   | out_x, out_y, out_z, w_zero
//  cfg_*    | in  | cfg_we        | cfg_idx, cfg_data (matrix registers)
//
//  One point per cycle enters while the output is not stalled; the stages are:
//  multiply, sum, magnitude, range check, 33 restoring divide stages (one
//  quotient bit each), and the output register.
//  The pipeline advances as one: a stalled output holds every stage.
//  Synchronous active-low reset clears valid bits and loads the identity.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_unit #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  hpt_point_if.sink          in_if,
  hpt_result_if.source       out_if,
  input  logic               cfg_we,
  input  hpt_pkg::cfg_idx_t  cfg_idx,
  input  hpt_pkg::cfg_word_t cfg_data
);
  import hpt_pkg::*;

  localparam int PW = 2 * COORD_W;        // product width
  localparam int HW = PW + 2;             // column sum width, signed
  localparam int MW = HW;                 // magnitude width
  localparam int QW = COORD_W + 1;        // quotient bits kept
  localparam int RW = MW + QW;            // remainder / shifted divisor width
  localparam logic [QW-1:0] NEG_LIMIT = QW'(1) << (COORD_W - 1);
  localparam coord_t MAX_POS = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t MAX_NEG = {1'b1, {(COORD_W-1){1'b0}}};

  logic en;

  // Matrix registers
  cfg_word_t mat_r [MAT_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_REGS; i++) mat_r[i] <= MAT_RESET[i];
    end else if (cfg_we) begin
      mat_r[cfg_idx] <= cfg_data;
    end
  end

  // Element (row, col), rows 0..3, cols 0..3
  coord_t m_el [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m_el[r][c] = (c % 2 == 1) ? mat_r[r*2 + c/2][CFG_W-1:COORD_W]
                                  : mat_r[r*2 + c/2][COORD_W-1:0];
      end
    end
  end

  // Global advance
  logic out_valid_r;
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // Stage 1: products
  logic s1_valid_r;
  logic signed [PW-1:0] s1_prod_r [4][3];
  coord_t s1_trans_r [4];
  coord_t pt [3];
  assign pt[0] = in_if.point_x;
  assign pt[1] = in_if.point_y;
  assign pt[2] = in_if.point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (en) s1_valid_r <= in_if.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) s1_prod_r[c][r] <= pt[r] * m_el[r][c];
        s1_trans_r[c] <= m_el[3][c];
      end
    end
  end

  // Stage 2: column sums, exact
  logic s2_valid_r;
  logic signed [HW-1:0] s2_h_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else if (en) s2_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        s2_h_r[c] <= HW'(s1_prod_r[c][0]) + HW'(s1_prod_r[c][1]) + HW'(s1_prod_r[c][2])
                   + (HW'(s1_trans_r[c]) <<< FRAC_BITS);
      end
    end
  end

  // Stage 3: magnitudes and signs
  logic s3_valid_r;
  logic [MW-1:0] s3_mag_r [3];
  logic [2:0] s3_neg_r;
  logic [MW-1:0] s3_d_r;
  logic s3_wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_valid_r <= 1'b0;
    else if (en) s3_valid_r <= s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s3_mag_r[c] <= s2_h_r[c][HW-1] ? MW'(-s2_h_r[c]) : MW'(s2_h_r[c]);
        s3_neg_r[c] <= s2_h_r[c][HW-1] ^ s2_h_r[3][HW-1];
      end
      s3_d_r  <= s2_h_r[3][HW-1] ? MW'(-s2_h_r[3]) : MW'(s2_h_r[3]);
      s3_wz_r <= (s2_h_r[3] == '0);
    end
  end

  // Divide pipeline; index 0 is the range-check stage
  logic          dv_valid_r [QW+1];
  logic [RW-1:0] dv_rem_r   [QW+1][3];
  logic [QW-1:0] dv_q_r     [QW+1][3];
  logic [2:0]    dv_ovf_r   [QW+1];
  logic [2:0]    dv_neg_r   [QW+1];
  logic [MW-1:0] dv_d_r     [QW+1];
  logic          dv_wz_r    [QW+1];

  // Stage 4: scale numerator, flag quotients of 2^QW or more
  always_ff @(posedge clk) begin
    if (!rst_n) dv_valid_r[0] <= 1'b0;
    else if (en) dv_valid_r[0] <= s3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dv_rem_r[0][c] <= RW'(s3_mag_r[c]) << FRAC_BITS;
        dv_q_r[0][c]   <= '0;
        dv_ovf_r[0][c] <= (RW'(s3_mag_r[c]) << FRAC_BITS) >= (RW'(s3_d_r) << QW);
      end
      dv_neg_r[0] <= s3_neg_r;
      dv_d_r[0]   <= s3_d_r;
      dv_wz_r[0]  <= s3_wz_r;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic [RW-1:0] dsh;
    assign dsh = RW'(dv_d_r[k]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_valid_r[k+1] <= 1'b0;
      else if (en) dv_valid_r[k+1] <= dv_valid_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          if (dv_rem_r[k][c] >= dsh) begin
            dv_rem_r[k+1][c] <= dv_rem_r[k][c] - dsh;
            dv_q_r[k+1][c]   <= {dv_q_r[k][c][QW-2:0], 1'b1};
          end else begin
            dv_rem_r[k+1][c] <= dv_rem_r[k][c];
            dv_q_r[k+1][c]   <= {dv_q_r[k][c][QW-2:0], 1'b0};
          end
        end
        dv_ovf_r[k+1] <= dv_ovf_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
        dv_d_r[k+1]   <= dv_d_r[k];
        dv_wz_r[k+1]  <= dv_wz_r[k];
      end
    end
  end

  // Sign, saturation, zero-w override
  coord_t res_nxt [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dv_wz_r[QW]) begin
        res_nxt[c] = '0;
      end else if (dv_neg_r[QW][c]) begin
        res_nxt[c] = (dv_ovf_r[QW][c] || dv_q_r[QW][c] > NEG_LIMIT) ? MAX_NEG
                   : -coord_t'(dv_q_r[QW][c][COORD_W-1:0]);
      end else begin
        res_nxt[c] = (dv_ovf_r[QW][c] || dv_q_r[QW][c][QW-1] || dv_q_r[QW][c][COORD_W-1])
                   ? MAX_POS : coord_t'(dv_q_r[QW][c][COORD_W-1:0]);
      end
    end
  end

  // Output register
  coord_t out_x_r, out_y_r, out_z_r;
  logic   w_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_valid_r[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r  <= res_nxt[0];
      out_y_r  <= res_nxt[1];
      out_z_r  <= res_nxt[2];
      w_zero_r <= dv_wz_r[QW];
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.out_x  = out_x_r;
  assign out_if.out_y  = out_y_r;
  assign out_if.out_z  = out_z_r;
  assign out_if.w_zero = w_zero_r;

`ifndef SYNTHESIS
  // Zero w forces all coordinates to zero
  a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && w_zero_r |-> out_x_r == '0 && out_y_r == '0 && out_z_r == '0)
    else $error("w_zero result with nonzero coordinates");

  // A waiting result freezes the whole pipeline
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> out_valid_r && $stable(out_x_r) && $stable(dv_valid_r[0]))
    else $error("pipeline moved during output stall");

  // A valid product stage moves into the sum stage when the pipeline advances
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && en |=> s2_valid_r)
    else $error("valid bit lost between product and sum stages");

  // The x quotient remainder stays below the divisor at the last stage
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid_r[QW] && !dv_wz_r[QW] && dv_ovf_r[QW] == 3'b000 |->
      dv_rem_r[QW][0] < RW'(dv_d_r[QW]))
    else $error("divide remainder not below divisor");
`endif

endmodule

// File: dv/hpt_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_tb_if
// Testbench copies of the point and result request channels are the RTL
// interfaces themselves; this file only holds the shared test constants.
// ----------------------------------------------------------------------------
package hpt_tb_pkg;
  import hpt_pkg::*;

  // Matrix register indexes
  typedef enum int {
    R1_C12 = 0, R1_C34 = 1, R2_C12 = 2, R2_C34 = 3,
    R3_C12 = 4, R3_C34 = 5, R4_C12 = 6, R4_C34 = 7
  } mat_reg_e;

  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
endpackage

// File: dv/tb_homogeneous_point_transform_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_homogeneous_point_transform_unit
// Streams points through the 4x4 transform with perspective divide under
// random idle gaps on both channels, and compares every projected point with
// a typed-in or exact 128-bit predicted result across several matrix settings.
// ----------------------------------------------------------------------------
module tb_homogeneous_point_transform_unit;
  import hpt_pkg::*;
  import hpt_tb_pkg::*;

  localparam int FB       = 16;
  localparam int LATENCY  = 38;
  localparam int WD_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
  } proj_t;

  // directed row: point, and an optional typed-in expectation
  typedef struct {
    logic [31:0] x, y, z;
    bit          known;
    proj_t       res;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_idx;
  cfg_word_t cfg_data;

  hpt_point_if  pt_if ();
  hpt_result_if res_if ();

  homogeneous_point_transform_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (pt_if),
    .out_if  (res_if),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  cfg_word_t mat_copy [MAT_REGS];
  proj_t     proj_q [$];
  int        err_cnt;
  int        idle_cnt;

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // matrix element, row/col from 0
  function automatic logic signed [127:0] elem(int row, int col);
    cfg_word_t r;
    r = mat_copy[row*2 + col/2];
    return (col % 2) ? 128'(signed'(r[63:32])) : 128'(signed'(r[31:0]));
  endfunction

  function automatic logic [31:0] div_sat(logic signed [127:0] h,
                                          logic signed [127:0] w);
    logic [127:0] nm, dm, q;
    bit           neg;
    neg = h[127] != w[127];
    nm  = h[127] ? -h : h;
    dm  = w[127] ? -w : w;
    q   = (nm << FB) / dm;
    if (neg) return (q > 128'h8000_0000) ? Q_MIN : 32'(-q);
    return (q > 128'h7FFF_FFFF) ? Q_MAX : q[31:0];
  endfunction

  function automatic proj_t project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    logic signed [127:0] p [3];
    logic signed [127:0] h [4];
    proj_t r;
    p[0] = 128'(signed'(px));
    p[1] = 128'(signed'(py));
    p[2] = 128'(signed'(pz));
    for (int c = 0; c < 4; c++) begin
      h[c] = elem(3, c) <<< FB;
      for (int k = 0; k < 3; k++) h[c] += p[k] * elem(k, c);
    end
    if (h[3] == 0) begin
      r = '{x: '0, y: '0, z: '0, wz: 1'b1};
    end else begin
      r.x = div_sat(h[0], h[3]);
      r.y = div_sat(h[1], h[3]);
      r.z = div_sat(h[2], h[3]);
      r.wz = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // result monitor and sink with random stalls
  initial begin
    int gap;
    proj_t want;
    res_if.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk iff res_if.valid);
      if (proj_q.size() == 0) begin
        report_mismatch("unexpected result", res_if.out_x, '0);
      end else begin
        want = proj_q.pop_front();
        if (res_if.out_x !== want.x) report_mismatch("out_x", res_if.out_x, want.x);
        if (res_if.out_y !== want.y) report_mismatch("out_y", res_if.out_y, want.y);
        if (res_if.out_z !== want.z) report_mismatch("out_z", res_if.out_z, want.z);
        if (res_if.w_zero !== want.wz)
          report_mismatch("w_zero", 32'(res_if.w_zero), 32'(want.wz));
      end
    end
  end

  // watchdog on accepted requests on either side
  always @(posedge clk) begin
    if (!rst_n || (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(mat_reg_e idx, cfg_word_t val);
    cfg_we   <= 1'b1;
    cfg_idx  <= cfg_idx_t'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mat_copy[idx] = val;
    @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            bit known, proj_t res);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= px;
    pt_if.point_y <= py;
    pt_if.point_z <= pz;
    @(posedge clk iff pt_if.ready);
    proj_q.push_back(known ? res : project(px, py, pz));
  endtask

  task automatic drain();
    pt_if.valid <= 1'b0;
    wait (proj_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(bit tame);
    case ($urandom_range(0, 5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return tame ? 32'(signed'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000)
                           : $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return Q_ONE;
      4: return $urandom;
      default: return 32'(signed'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
    endcase
  endfunction

  initial begin
    dir_row_t dir_tab [$];
    proj_t    z0;
    bit       tame;
    z0 = '0;
    err_cnt      = 0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    pt_if.valid  <= 1'b0;
    pt_if.point_x <= '0;
    pt_if.point_y <= '0;
    pt_if.point_z <= '0;
    for (int i = 0; i < MAT_REGS; i++) mat_copy[i] = MAT_RESET[i];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset: result equals the point
    dir_tab = '{
      '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1,
        '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0}},
      '{Q_MAX, Q_MIN, 32'h0, 1, '{Q_MAX, Q_MIN, 32'h0, 1'b0}},
      '{Q_MIN, Q_MAX, 32'hFFFF_FFFF, 1, '{Q_MIN, Q_MAX, 32'hFFFF_FFFF, 1'b0}},
      '{32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 1'b0}}
    };
    foreach (dir_tab[i]) send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                                    dir_tab[i].known, dir_tab[i].res);
    drain();

    // w column all zero: zero-w flag for every point
    write_reg(R4_C34, 64'h0);
    dir_tab = '{
      '{32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 1, '{x: '0, y: '0, z: '0, wz: 1'b1}},
      '{Q_MIN, Q_MIN, Q_MIN, 1, '{x: '0, y: '0, z: '0, wz: 1'b1}}
    };
    foreach (dir_tab[i]) send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                                    dir_tab[i].known, dir_tab[i].res);
    drain();

    // tiny w: quotients saturate both ways; negative w flips signs
    write_reg(R4_C34, {32'h0000_0001, 32'h0});
    write_reg(R4_C12, {32'h8000_0000, 32'h7FFF_FFFF});
    dir_tab = '{
      '{32'h0, 32'h0, 32'h0, 1, '{Q_MAX, Q_MIN, 32'h0, 1'b0}},
      '{32'h0001_0000, 32'h0, 32'h0, 0, z0},
      '{Q_MAX, Q_MAX, Q_MAX, 0, z0}
    };
    foreach (dir_tab[i]) send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                                    dir_tab[i].known, dir_tab[i].res);
    drain();
    write_reg(R4_C34, {32'hFFFF_0000, 32'h0001_0000});
    dir_tab = '{
      '{32'h0002_0000, 32'hFFFD_0000, 32'h0000_0001, 0, z0},
      '{Q_MIN, Q_MAX, Q_MIN, 0, z0}
    };
    foreach (dir_tab[i]) send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                                    dir_tab[i].known, dir_tab[i].res);
    drain();

    // random phases, each with a fresh matrix; the first two use extremes
    for (int ph = 0; ph < 14; ph++) begin
      for (int r = 0; r < MAT_REGS; r++) begin
        if (ph == 0) write_reg(mat_reg_e'(r), {Q_MAX, Q_MAX});
        else if (ph == 1) write_reg(mat_reg_e'(r), {Q_MIN, Q_MIN});
        else write_reg(mat_reg_e'(r), {rnd_elem(), rnd_elem()});
      end
      // keep w sane most of the time so quotients land in range
      if (ph > 1 && $urandom_range(0, 2) != 0)
        write_reg(R4_C34, {Q_ONE + 32'($urandom_range(0, 255)), rnd_elem()});
      tame = $urandom_range(0, 2) != 0;
      for (int n = 0; n < 100; n++)
        send_point(rnd_coord(tame), rnd_coord(tame), rnd_coord(tame), 0, z0);
      drain();
    end

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
